### sv/vector_step_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Vector step interpolator assertion macros
// Shared concurrent assertion forms for the vector step interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef VECTOR_STEP_INTERPOLATOR_DEFINES_SVH
`define VECTOR_STEP_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define VSI_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define VSI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
else $error(msg);

`endif

### sv/vsi_pkg.sv
// ----------------------------------------------------------------------------
// Vector step interpolator package
// Widths, command codes, state type and divider status shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package vsi_pkg;

	// Width of the frame countdown (4 to 31).
	localparam int FRAME_BITS = 16;

	localparam int POS_W      = 16;
	localparam int FRAMES_W   = 16;
	localparam int EXT_W      = 32;
	localparam int AXES       = 3;
	localparam int AXIS_W     = $clog2(AXES);

	// Magnitude of a target-minus-position difference and of its quotient.
	localparam int QUO_W      = POS_W + 1;
	localparam int DIV_STEPS  = QUO_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [QUO_W-1:0]      quo_t;

	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} vsi_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} vsi_div_stat_t;

endpackage

`default_nettype wire

### sv/vsi_if.sv
// ----------------------------------------------------------------------------
// Vector step interpolator channels
// Command and result word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vsi_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  command;
	logic signed [vsi_pkg::POS_W-1:0] value_x;
	logic signed [vsi_pkg::POS_W-1:0] value_y;
	logic signed [vsi_pkg::POS_W-1:0] value_z;
	logic [vsi_pkg::FRAMES_W-1:0] frames;

	modport source (output valid, command, value_x, value_y, value_z, frames, input ready);
	modport sink   (input valid, command, value_x, value_y, value_z, frames, output ready);
endinterface

interface vsi_res_if;
	logic                        valid;
	logic                        ready;
	logic signed [vsi_pkg::POS_W-1:0] pos_x;
	logic signed [vsi_pkg::POS_W-1:0] pos_y;
	logic signed [vsi_pkg::POS_W-1:0] pos_z;
	logic [vsi_pkg::FRAMES_W-1:0] frames_left;
	logic                        arrived;

	modport source (output valid, pos_x, pos_y, pos_z, frames_left, arrived, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, frames_left, arrived, output ready);
endinterface

`default_nettype wire

### sv/vsi_div.sv
// ----------------------------------------------------------------------------
// Vector step interpolator divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_step_interpolator_defines.svh"

module vsi_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire vsi_pkg::quo_t          dividend,
	input  wire vsi_pkg::frame_t        divisor,
	output vsi_pkg::vsi_div_stat_t      stat,
	output vsi_pkg::quo_t               quotient
);

	logic                             busy_q;
	logic                             done_q;
	logic [vsi_pkg::STEP_CNT_W-1:0]   cnt_q;
	vsi_pkg::frame_t                  rem_q;
	vsi_pkg::frame_t                  divisor_q;
	vsi_pkg::quo_t                    quo_q;

	logic [vsi_pkg::FRAME_BITS:0]     trial;
	logic [vsi_pkg::FRAME_BITS:0]     trial_sub;
	logic                             fits;

	// Shift the next dividend bit into the partial remainder.
	always_comb begin
		trial     = {rem_q, quo_q[vsi_pkg::QUO_W-1]};
		trial_sub = trial - {1'b0, divisor_q};
		fits      = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == vsi_pkg::STEP_CNT_W'(vsi_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Dividend bits leave at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[vsi_pkg::FRAME_BITS-1:0] : trial[vsi_pkg::FRAME_BITS-1:0];
			quo_q <= {quo_q[vsi_pkg::QUO_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	`VSI_ASSERT_NOW(a_div_no_restart, clk, arst_n, start, !busy_q, "divider restarted while busy")
	`VSI_ASSERT_NOW(a_div_done_idle, clk, arst_n, done_q, !busy_q, "divider done while busy")
	`VSI_ASSERT_NOW(a_div_rem_bound, clk, arst_n, busy_q && (cnt_q != '0), rem_q < divisor_q, "partial remainder not below divisor")

endmodule

`default_nettype wire

### sv/vector_step_interpolator.sv
// ----------------------------------------------------------------------------
// Vector step interpolator
// Three-axis linear move toward a target with a frame countdown.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word: set position, start move (target plus
//   frame count) or tick one frame. res returns exactly one result word per
//   command: the position after it, the frames left and an arrived flag.
//   A word moves on a clock edge with valid and ready both high.
// Sequencing (result register free):
//   Set, start, idle tick and the unused code: the command is taken in idle,
//   the emit state loads the result register and the block returns to idle.
//   A tick of a running move divides all three axes in turn on one bit-serial
//   divider (a start state, the quotient bits, then a hand-off in the wait
//   state); after the last axis the emit state loads the result. No new
//   command is taken until the block is back in idle.
// Reset (arst_n low): position, target and countdown clear to zero (idle),
//   no result is pending.
// Stall: the result register holds while res.ready is low; a new command is
//   still taken and worked on, and its result waits until the old word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_step_interpolator_defines.svh"

module vector_step_interpolator (
	input  wire logic clk,
	input  wire logic arst_n,
	vsi_cmd_if.sink   cmd,
	vsi_res_if.source res
);

	// Axis state: slot 0 is always the axis the divider works on; the slots
	// rotate once per axis so three rotations bring them back in order.
	vsi_pkg::pos_t                cur_q [vsi_pkg::AXES];
	vsi_pkg::pos_t                tgt_q [vsi_pkg::AXES];
	vsi_pkg::frame_t              rem_q;
	logic                         arrived_q;
	logic [vsi_pkg::AXIS_W-1:0]   axis_q;

	vsi_pkg::vsi_state_t          state_q;
	vsi_pkg::vsi_state_t          state_d;

	// Result register.
	logic                         out_valid_q;
	vsi_pkg::pos_t                pos_x_q;
	vsi_pkg::pos_t                pos_y_q;
	vsi_pkg::pos_t                pos_z_q;
	logic [vsi_pkg::FRAMES_W-1:0] frames_left_q;
	logic                         arrived_out_q;

	logic                         in_fire;
	logic                         div_start;
	logic                         out_load;
	logic                         last_axis;

	logic [vsi_pkg::EXT_W-1:0]    frames_ext;
	logic [vsi_pkg::EXT_W-1:0]    rem_ext;
	vsi_pkg::frame_t              rem_load;
	vsi_pkg::frame_t              rem_dec;

	logic [vsi_pkg::QUO_W-1:0]    pos_ext;
	logic [vsi_pkg::QUO_W-1:0]    diff;
	vsi_pkg::quo_t                mag;
	vsi_pkg::quo_t                quotient;
	logic [vsi_pkg::QUO_W-1:0]    step_sum;
	vsi_pkg::pos_t                new_pos;

	vsi_pkg::vsi_div_stat_t       div_stat;

	// Mask frames to the counter width; show the low bits of the countdown.
	assign frames_ext = {{(vsi_pkg::EXT_W - vsi_pkg::FRAMES_W){1'b0}}, cmd.frames};
	assign rem_load   = frames_ext[vsi_pkg::FRAME_BITS-1:0];
	assign rem_ext    = {{(vsi_pkg::EXT_W - vsi_pkg::FRAME_BITS){1'b0}}, rem_q};
	assign rem_dec    = rem_q - 1'b1;
	assign last_axis  = (axis_q == vsi_pkg::AXIS_W'(vsi_pkg::AXES - 1));

	// Difference to target, its magnitude for the divider, and the step back
	// with the sign applied. The step lands between position and target.
	always_comb begin
		pos_ext  = {cur_q[0][vsi_pkg::POS_W-1], cur_q[0]};
		diff     = {tgt_q[0][vsi_pkg::POS_W-1], tgt_q[0]} - pos_ext;
		mag      = diff[vsi_pkg::QUO_W-1] ? (vsi_pkg::QUO_W'(0) - diff) : diff;
		step_sum = diff[vsi_pkg::QUO_W-1] ? (pos_ext - quotient) : (pos_ext + quotient);
		new_pos  = step_sum[vsi_pkg::POS_W-1:0];
	end

	vsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (rem_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Sequencer: next state and strobes.
	always_comb begin
		state_d   = state_q;
		in_fire   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		cmd.ready = 1'b0;
		unique case (state_q)
			vsi_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				in_fire   = cmd.valid;
				if (cmd.valid) begin
					if (cmd.command == vsi_pkg::CMD_TICK && rem_q != '0) begin
						state_d = vsi_pkg::ST_DIV_GO;
					end else begin
						state_d = vsi_pkg::ST_EMIT;
					end
				end
			end
			vsi_pkg::ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = vsi_pkg::ST_DIV_WAIT;
			end
			vsi_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = last_axis ? vsi_pkg::ST_EMIT : vsi_pkg::ST_DIV_GO;
				end
			end
			vsi_pkg::ST_EMIT: begin
				out_load = !out_valid_q || res.ready;
				if (out_load) begin
					state_d = vsi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vsi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vsi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Position, target and countdown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < vsi_pkg::AXES; a++) begin
				cur_q[a] <= '0;
				tgt_q[a] <= '0;
			end
			rem_q     <= '0;
			arrived_q <= 1'b0;
			axis_q    <= '0;
		end else if (in_fire) begin
			axis_q    <= '0;
			arrived_q <= 1'b0;
			unique case (cmd.command)
				vsi_pkg::CMD_SET: begin
					cur_q[0] <= cmd.value_x;
					cur_q[1] <= cmd.value_y;
					cur_q[2] <= cmd.value_z;
				end
				vsi_pkg::CMD_START: begin
					tgt_q[0] <= cmd.value_x;
					tgt_q[1] <= cmd.value_y;
					tgt_q[2] <= cmd.value_z;
					rem_q    <= rem_load;
					// Zero frames: snap at once.
					if (rem_load == '0) begin
						cur_q[0]  <= cmd.value_x;
						cur_q[1]  <= cmd.value_y;
						cur_q[2]  <= cmd.value_z;
						arrived_q <= 1'b1;
					end
				end
				vsi_pkg::CMD_TICK: begin
				end
				default: begin
				end
			endcase
		end else if (state_q == vsi_pkg::ST_DIV_WAIT && div_stat.done) begin
			// Advance one axis: write the stepped value and rotate the slots.
			tgt_q[0] <= tgt_q[1];
			tgt_q[1] <= tgt_q[2];
			tgt_q[2] <= tgt_q[0];
			axis_q   <= axis_q + 1'b1;
			if (last_axis && rem_dec == '0) begin
				// Move done: snap to the target in rotated order.
				cur_q[0]  <= tgt_q[1];
				cur_q[1]  <= tgt_q[2];
				cur_q[2]  <= tgt_q[0];
				arrived_q <= 1'b1;
			end else begin
				cur_q[0] <= cur_q[1];
				cur_q[1] <= cur_q[2];
				cur_q[2] <= new_pos;
			end
			if (last_axis) begin
				rem_q <= rem_dec;
			end
		end
	end

	// Result register: hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x_q       <= cur_q[0];
			pos_y_q       <= cur_q[1];
			pos_z_q       <= cur_q[2];
			frames_left_q <= rem_ext[vsi_pkg::FRAMES_W-1:0];
			arrived_out_q <= arrived_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.pos_x       = pos_x_q;
	assign res.pos_y       = pos_y_q;
	assign res.pos_z       = pos_z_q;
	assign res.frames_left = frames_left_q;
	assign res.arrived     = arrived_out_q;

	`VSI_ASSERT_NOW(a_done_in_wait, clk, arst_n, div_stat.done,
		state_q == vsi_pkg::ST_DIV_WAIT, "divider finished outside wait state")
	`VSI_ASSERT_NOW(a_busy_in_wait, clk, arst_n, div_stat.busy,
		state_q == vsi_pkg::ST_DIV_WAIT, "divider busy outside wait state")
	`VSI_ASSERT_NEXT(a_tick_divides, clk, arst_n,
		in_fire && cmd.command == vsi_pkg::CMD_TICK && rem_q != '0,
		state_q == vsi_pkg::ST_DIV_GO, "running tick did not start division")
	`VSI_ASSERT_NOW(a_arrived_idle, clk, arst_n, res.valid && res.arrived,
		res.frames_left == '0, "arrived with frames left")

endmodule

`default_nettype wire

### tb/vsi_track_checker.sv
// ----------------------------------------------------------------------------
// Vector step interpolator track checker
// Watches the command and result channels, predicts the position, countdown
// and arrived flag of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module vsi_track_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	vsi_cmd_if        cmd,
	vsi_res_if        res,
	output int        errors,
	output int        pending,
	output int        results_seen,
	output int        arrivals_seen
);
	import vsi_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		pos_t                x;
		pos_t                y;
		pos_t                z;
		logic [FRAMES_W-1:0] left;
		logic                arrived;
	} track_word_t;

	pos_t        position [AXES];
	pos_t        target   [AXES];
	frame_t      countdown;
	track_word_t expected_track [$];

	// Apply one command to the tracked state and return the word it produces.
	function automatic track_word_t step_motion(input logic [1:0] op, input pos_t vx,
		input pos_t vy, input pos_t vz, input logic [FRAMES_W-1:0] nframes);
		pos_t        given [AXES];
		track_word_t word;
		int          from;
		int          to;
		int          a;
		word     = '0;
		given[0] = vx;
		given[1] = vy;
		given[2] = vz;
		case (op)
			CMD_SET: begin
				for (a = 0; a < AXES; a++)
					position[a] = given[a];
			end
			CMD_START: begin
				for (a = 0; a < AXES; a++)
					target[a] = given[a];
				countdown = frame_t'(nframes);
				// zero frames: land on the target at once
				if (countdown == '0) begin
					for (a = 0; a < AXES; a++)
						position[a] = target[a];
					word.arrived = 1'b1;
				end
			end
			CMD_TICK: begin
				// a tick with no move running leaves everything alone
				if (countdown != '0) begin
					for (a = 0; a < AXES; a++) begin
						from        = int'($signed(position[a]));
						to          = int'($signed(target[a]));
						position[a] = pos_t'(from + (to - from) / int'(countdown));
					end
					countdown = countdown - 1'b1;
					if (countdown == '0) begin
						for (a = 0; a < AXES; a++)
							position[a] = target[a];
						word.arrived = 1'b1;
					end
				end
			end
			default: ;
		endcase
		word.x    = position[0];
		word.y    = position[1];
		word.z    = position[2];
		word.left = FRAMES_W'(countdown);
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		track_word_t seen;
		track_word_t want;
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				position[a] = '0;
				target[a]   = '0;
			end
			countdown = '0;
			expected_track.delete();
			errors        <= 0;
			pending       <= 0;
			results_seen  <= 0;
			arrivals_seen <= 0;
		end else begin
			// check the outgoing word first: it always belongs to an older command
			if (res.valid && res.ready) begin
				seen.x       = res.pos_x;
				seen.y       = res.pos_y;
				seen.z       = res.pos_z;
				seen.left    = res.frames_left;
				seen.arrived = res.arrived;
				results_seen <= results_seen + 1;
				if (seen.arrived === 1'b1)
					arrivals_seen <= arrivals_seen + 1;
				if (expected_track.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("unexpected result word: x=%0d y=%0d z=%0d left=%0d arr=%b",
							$signed(seen.x), $signed(seen.y), $signed(seen.z),
							seen.left, seen.arrived);
					errors <= errors + 1;
				end else begin
					want = expected_track.pop_front();
					if (seen !== want) begin
						if (errors < REPORT_MAX) begin
							$write("result mismatch: expected x=%0d y=%0d z=%0d left=%0d arr=%b, ",
								$signed(want.x), $signed(want.y), $signed(want.z),
								want.left, want.arrived);
							$display("got x=%0d y=%0d z=%0d left=%0d arr=%b",
								$signed(seen.x), $signed(seen.y), $signed(seen.z),
								seen.left, seen.arrived);
						end
						errors <= errors + 1;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				expected_track.push_back(step_motion(cmd.command, cmd.value_x,
					cmd.value_y, cmd.value_z, cmd.frames));
			pending <= expected_track.size();
		end
	end

endmodule

`default_nettype wire

### tb/tb_vector_step_interpolator.sv
// ----------------------------------------------------------------------------
// Vector step interpolator testbench
// Drives set, start, tick and unused command words with random gaps against
// a receiver that stalls at random, floods the input while the output is held
// off, and lets the track checker compare every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vector_step_interpolator;
	import vsi_pkg::*;

	// The package names three codes; the fourth must still be harmless.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 9;
	localparam int WORDS_TARGET = 1600;
	localparam int DRAIN_EVERY  = 400;
	localparam int FLOOD_WORDS  = 8;
	// A running tick holds the input; at the end, wait longer than one such tick.
	localparam int DRAIN_CYCLES = 64;
	// Receiver hold-off for the flood phases; the watchdog sits well above it.
	localparam int LONG_HOLD    = 400;
	localparam int IDLE_LIMIT   = 4000;
	// Moves longer than this are cut short by a later start command.
	localparam int MAX_TICKS    = 45;

	logic clk;
	logic arst_n;

	vsi_cmd_if cmd_ch ();
	vsi_res_if res_ch ();

	int check_errors;
	int words_pending;
	int results_checked;
	int arrivals;

	int words_sent;
	int idle_cycles;
	bit gaps_on;
	bit hold_req;
	bit holding;
	bit mid_flood_done;
	int next_drain;

	vector_step_interpolator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	vsi_track_checker u_track_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.res           (res_ch),
		.errors        (check_errors),
		.pending       (words_pending),
		.results_seen  (results_checked),
		.arrivals_seen (arrivals)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Watchdog: count cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: %0d cycles without a handshake", idle_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Sender gap: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Axis value: lean on the range ends and on small steps around zero.
	function automatic pos_t rand_pos();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return '0;
			3:       return pos_t'($urandom_range(0, 16) - 8);
			default: return pos_t'($urandom);
		endcase
	endfunction

	// Move length: mostly short so moves finish, a few zero, long or full range.
	function automatic logic [FRAMES_W-1:0] rand_frames();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return FRAMES_W'($urandom_range(1, 6));
		else if (roll < 75)
			return FRAMES_W'($urandom_range(7, MAX_TICKS));
		else if (roll < 82)
			return '0;
		else if (roll < 90)
			return FRAMES_W'($urandom_range(MAX_TICKS + 1, 300));
		return FRAMES_W'($urandom);
	endfunction

	// Offer one command word and hold it until the block takes it. Valid stays
	// high into the next word when there is no gap.
	task automatic send_word(input logic [1:0] op, input pos_t vx, input pos_t vy,
		input pos_t vz, input logic [FRAMES_W-1:0] nframes);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.value_x <= vx;
		cmd_ch.value_y <= vy;
		cmd_ch.value_z <= vz;
		cmd_ch.frames  <= nframes;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	// Any command with any fields, unused code included.
	task automatic send_noise();
		send_word(2'($urandom_range(0, 3)), rand_pos(), rand_pos(), rand_pos(), rand_frames());
	endtask

	// Drop valid and hold until every expected result word has come back.
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
	endtask

	// Ask the receiver for a long hold-off, then push fast words back to back so
	// the result register fills and the block stalls its input.
	task automatic flood_while_held();
		logic [1:0] op;
		cmd_ch.valid <= 1'b0;
		hold_req = 1'b1;
		do @(posedge clk); while (!holding);
		gaps_on = 1'b0;
		for (int n = 0; n < FLOOD_WORDS; n++) begin
			case ($urandom_range(0, 2))
				0:       op = CMD_SET;
				1:       op = CMD_START;
				default: op = CMD_UNUSED;
			endcase
			// a start with zero frames keeps every word on the fast path
			send_word(op, rand_pos(), rand_pos(), rand_pos(), '0);
		end
		gaps_on = 1'b1;
	endtask

	// One move: maybe place the axes, start, tick it through (or cut a long one
	// short), with a stray word now and then in the middle.
	task automatic run_move();
		logic [FRAMES_W-1:0] nframes;
		int                  ticks;
		if ($urandom_range(0, 1))
			send_word(CMD_SET, rand_pos(), rand_pos(), rand_pos(), FRAMES_W'($urandom));
		nframes = rand_frames();
		send_word(CMD_START, rand_pos(), rand_pos(), rand_pos(), nframes);
		ticks = (nframes > MAX_TICKS) ? $urandom_range(1, 6) : int'(nframes);
		for (int k = 0; k < ticks; k++) begin
			if ($urandom_range(0, 19) == 0)
				send_noise();
			send_word(CMD_TICK, rand_pos(), rand_pos(), rand_pos(), FRAMES_W'($urandom));
		end
		// tick again now and then: usually lands on an idle block
		if ($urandom_range(0, 3) == 0)
			send_word(CMD_TICK, rand_pos(), rand_pos(), rand_pos(), FRAMES_W'($urandom));
	endtask

	// Receiver: random ready pattern, with a long hold-off when asked for one.
	initial begin : receiver
		int roll;
		int span;
		res_ch.ready <= 1'b0;
		holding = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				holding  = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holding = 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					res_ch.ready <= 1'b1;
					span = $urandom_range(1, 24);
				end else if (roll < 50) begin
					// stretch with no stalls at all
					res_ch.ready <= 1'b1;
					span = $urandom_range(100, 300);
				end else if (roll < 92) begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(1, 4);
				end else begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(20, 80);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	// Sender and verdict.
	initial begin : sender
		cmd_ch.valid   <= 1'b0;
		cmd_ch.command <= CMD_SET;
		cmd_ch.value_x <= '0;
		cmd_ch.value_y <= '0;
		cmd_ch.value_z <= '0;
		cmd_ch.frames  <= '0;
		arst_n         = 1'b0;
		hold_req       = 1'b0;
		gaps_on        = 1'b1;
		mid_flood_done = 1'b0;
		words_sent     = 0;
		next_drain     = DRAIN_EVERY;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick and unused code straight out of reset.
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_UNUSED, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
		// Full-range jump in one frame, then a tick after arrival.
		send_word(CMD_SET,    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
		send_word(CMD_START,  16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// Small odd steps: quotients truncate toward zero on both signs.
		send_word(CMD_SET,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_START,  16'hFFF9, 16'h0007, 16'hFFFF, 16'h0003);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// Set in the middle of a move: the move goes on from the new point.
		send_word(CMD_SET,    16'h8000, 16'h8000, 16'h8000, 16'h0000);
		send_word(CMD_START,  16'h7FFF, 16'h7FFF, 16'h0001, 16'h0002);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_SET,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// Zero frames snaps at once.
		send_word(CMD_START,  16'h1234, 16'hEDCC, 16'h7FFF, 16'h0000);
		// Longest move: a few ticks, unused code, then cut short by a snap.
		send_word(CMD_START,  16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(CMD_START,  16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
		send_word(CMD_TICK,   16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		drain_results();

		flood_while_held();
		drain_results();

		// Random: mostly complete moves, the rest loose words.
		while (words_sent < WORDS_TARGET) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 78)
				run_move();
			else
				send_noise();
			gaps_on = 1'b1;
			if (!mid_flood_done && words_sent >= WORDS_TARGET / 2) begin
				flood_while_held();
				mid_flood_done = 1'b1;
			end
			if (words_sent >= next_drain) begin
				drain_results();
				next_drain += DRAIN_EVERY;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d command words and %0d checked results, %0d with arrived set",
			words_sent, results_checked, arrivals);
		$display("output held off for %0d cycles twice while the input was flooded", LONG_HOLD);
		if (check_errors == 0 && words_pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (words_pending != 0)
				$display("%0d expected result words never arrived", words_pending);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/vsi_pkg.sv
sv/vsi_if.sv
sv/vsi_div.sv
sv/vector_step_interpolator.sv
tb/vsi_track_checker.sv
tb/tb_vector_step_interpolator.sv
